>>> rtl/core/kst_pkg.sv
// Shared types, constants and register codes of the kinetic scroll tracker.
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

    // Sequencer step counter width
    localparam int STEP_W = 6;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_TAG    = 2'd0;
    localparam logic [1:0] REG_DECEL  = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_INVERT = 2'd3;

    // Arithmetic constants
    localparam logic [6:0]         DEFAULT_PCT = 7'd5;
    localparam logic [6:0]         PCT_BASE    = 7'd100;
    localparam logic signed [31:0] MIN_SPEED   = 32'sd2;
    localparam logic [4:0]         ANGLE_SCALE = 5'd20;

    // Divide-by-constant: divisor and floor(2^32 / divisor)
    localparam logic [31:0] DIV100_D = 32'd100;
    localparam logic [31:0] DIV100_M = 32'd42949672;
    localparam logic [31:0] DIV36K_D = 32'd36000;
    localparam logic [31:0] DIV36K_M = 32'd119304;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_SG,
        OP_MUL_VD,
        OP_MUL_ANG,
        OP_DIV_PROD100,
        OP_DIV_PROD36K,
        OP_DIV_ANG100,
        OP_COMMIT,
        OP_DECAY,
        OP_STOP,
        OP_PRESS,
        OP_FLING,
        OP_SETTLE,
        OP_DRAW,
        OP_SET_ANG,
        OP_SET_DEG,
        OP_EMIT
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_NOT_FIRST,
        C_NOT_ROLL,
        C_PRESS,
        C_FLING,
        C_VEL_ZERO,
        C_DECEL_FULL,
        C_DIV_BUSY,
        C_OUT_FULL
    } t_cond;

    // One microcode word
    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Status from datapath to sequencer
    typedef struct packed {
        logic no_item;
        logic first_hit;
        logic rolling;
        logic press_hit;
        logic fling_hit;
        logic vel_zero;
        logic decel_full;
        logic div_busy;
        logic out_full;
    } t_flags;

    // Configuration registers
    typedef struct packed {
        logic [7:0] tag;
        logic [6:0] decel;
        logic [7:0] gain;
        logic       invert;
    } t_cfg;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic        big;
        logic [31:0] x;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> rtl/core/kst_if.sv
// Valid/ready channel interfaces for gesture samples and scroll results.
`timescale 1ns / 1ps
`default_nettype none
interface kst_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         first_press_tag;
    logic [7:0]         press_tag;
    logic [7:0]         velocity_tag;
    logic signed [15:0] drag_distance;
    logic signed [15:0] fling_velocity;
    logic signed [31:0] fling_total;

    modport source (
        output valid, first_press_tag, press_tag, velocity_tag,
               drag_distance, fling_velocity, fling_total,
        input  ready
    );
    modport sink (
        input  valid, first_press_tag, press_tag, velocity_tag,
               drag_distance, fling_velocity, fling_total,
        output ready
    );
endinterface

interface kst_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] render_pos;
    logic signed [16:0] angle_hundredths;
    logic signed [9:0]  angle_degrees;

    modport source (
        output valid, render_pos, angle_hundredths, angle_degrees,
        input  ready
    );
    modport sink (
        input  valid, render_pos, angle_hundredths, angle_degrees,
        output ready
    );
endinterface
`default_nettype wire

>>> rtl/core/kst_cdiv.sv
// Signed divide by 100 or 36000 with truncation, reciprocal multiply and correction.
`timescale 1ns / 1ps
`default_nettype none
module kst_cdiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kst_pkg::t_div_req i_req,
    output kst_pkg::t_div_rsp o_rsp
);
    import kst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MHI  = 5'b00010,
        S_MLO  = 5'b00100,
        S_FIX  = 5'b01000,
        S_SIGN = 5'b10000
    } t_dstate;

    t_dstate     r_state, n_state;
    logic        r_neg, r_big;
    logic [31:0] r_mag, r_q0, r_t, r_qu, r_ru, r_quot, r_rem;
    logic [31:0] w_m, w_d, w_lo, w_diff;
    logic [63:0] w_hi;

    // Constant select
    assign w_m = r_big ? DIV36K_M : DIV100_M;
    assign w_d = r_big ? DIV36K_D : DIV100_D;

    // Estimate quotient from the high word, then back-multiply
    assign w_hi   = {32'd0, r_mag} * {32'd0, w_m};
    assign w_lo   = r_q0 * w_d;
    assign w_diff = r_mag - r_t;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.start) n_state = S_MHI;
            S_MHI:  n_state = S_MLO;
            S_MLO:  n_state = S_FIX;
            S_FIX:  n_state = S_SIGN;
            S_SIGN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    r_neg <= i_req.x[31];
                    r_big <= i_req.big;
                    r_mag <= i_req.x[31] ? (32'd0 - i_req.x) : i_req.x;
                end
            end
            S_MHI: r_q0 <= w_hi[63:32];
            S_MLO: r_t  <= w_lo;
            S_FIX: begin
                // estimate is at most one low
                if (w_diff >= w_d) begin
                    r_qu <= r_q0 + 32'd1;
                    r_ru <= w_diff - w_d;
                end else begin
                    r_qu <= r_q0;
                    r_ru <= w_diff;
                end
            end
            S_SIGN: begin
                r_quot <= r_neg ? (32'd0 - r_qu) : r_qu;
                r_rem  <= r_neg ? (32'd0 - r_ru) : r_ru;
            end
            default: ;
        endcase
    end

    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

>>> rtl/core/kst_seq.sv
// Microcode sequencer: program table, step counter and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none
module kst_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kst_pkg::t_flags i_flags,
    output kst_pkg::t_uword o_uw
);
    import kst_pkg::*;

    // Program labels
    localparam logic [STEP_W-1:0] ST_IDLE  = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_ROLL  = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_DIV_A = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_DIV_B = STEP_W'(13);
    localparam logic [STEP_W-1:0] ST_STOP  = STEP_W'(15);
    localparam logic [STEP_W-1:0] ST_PRESS = STEP_W'(16);
    localparam logic [STEP_W-1:0] ST_FLING = STEP_W'(17);
    localparam logic [STEP_W-1:0] ST_SETL  = STEP_W'(18);
    localparam logic [STEP_W-1:0] ST_DIV_C = STEP_W'(20);
    localparam logic [STEP_W-1:0] ST_DRAW  = STEP_W'(22);
    localparam logic [STEP_W-1:0] ST_DIV_D = STEP_W'(24);
    localparam logic [STEP_W-1:0] ST_DIV_E = STEP_W'(28);
    localparam logic [STEP_W-1:0] ST_DIV_F = STEP_W'(31);
    localparam logic [STEP_W-1:0] ST_EMIT  = STEP_W'(33);

    logic [STEP_W-1:0] r_step, n_step;
    t_uword            w_uw;
    logic              w_take;

    function automatic t_uword f_uw(input t_op op, input t_cond cond,
                                    input logic [STEP_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Program table
    function automatic t_uword f_rom(input logic [STEP_W-1:0] s);
        t_uword w;
        unique case (s)
            // wait for a sample and latch it
            6'd0:  w = f_uw(OP_LOAD,        C_NO_ITEM,    ST_IDLE);
            // first press on this tag commits pending motion
            6'd1:  w = f_uw(OP_NOP,         C_NOT_FIRST,  ST_ROLL);
            6'd2:  w = f_uw(OP_MUL_SG,      C_NEVER,      ST_IDLE);
            6'd3:  w = f_uw(OP_DIV_PROD100, C_NEVER,      ST_IDLE);
            6'd4:  w = f_uw(OP_NOP,         C_DIV_BUSY,   ST_DIV_A);
            6'd5:  w = f_uw(OP_COMMIT,      C_NEVER,      ST_IDLE);
            // gesture dispatch
            6'd6:  w = f_uw(OP_NOP,         C_NOT_ROLL,   ST_EMIT);
            6'd7:  w = f_uw(OP_NOP,         C_PRESS,      ST_PRESS);
            6'd8:  w = f_uw(OP_NOP,         C_FLING,      ST_FLING);
            6'd9:  w = f_uw(OP_NOP,         C_VEL_ZERO,   ST_SETL);
            6'd10: w = f_uw(OP_NOP,         C_DECEL_FULL, ST_STOP);
            // friction decay
            6'd11: w = f_uw(OP_MUL_VD,      C_NEVER,      ST_IDLE);
            6'd12: w = f_uw(OP_DIV_PROD100, C_NEVER,      ST_IDLE);
            6'd13: w = f_uw(OP_NOP,         C_DIV_BUSY,   ST_DIV_B);
            6'd14: w = f_uw(OP_DECAY,       C_ALWAYS,     ST_DRAW);
            6'd15: w = f_uw(OP_STOP,        C_ALWAYS,     ST_DRAW);
            6'd16: w = f_uw(OP_PRESS,       C_ALWAYS,     ST_DRAW);
            6'd17: w = f_uw(OP_FLING,       C_ALWAYS,     ST_DRAW);
            // still: fold motion into the base position
            6'd18: w = f_uw(OP_MUL_SG,      C_NEVER,      ST_IDLE);
            6'd19: w = f_uw(OP_DIV_PROD100, C_NEVER,      ST_IDLE);
            6'd20: w = f_uw(OP_NOP,         C_DIV_BUSY,   ST_DIV_C);
            6'd21: w = f_uw(OP_SETTLE,      C_NEVER,      ST_IDLE);
            // draw position
            6'd22: w = f_uw(OP_MUL_SG,      C_NEVER,      ST_IDLE);
            6'd23: w = f_uw(OP_DIV_PROD100, C_NEVER,      ST_IDLE);
            6'd24: w = f_uw(OP_NOP,         C_DIV_BUSY,   ST_DIV_D);
            6'd25: w = f_uw(OP_DRAW,        C_NEVER,      ST_IDLE);
            // angle in hundredths, then whole degrees
            6'd26: w = f_uw(OP_MUL_ANG,     C_NEVER,      ST_IDLE);
            6'd27: w = f_uw(OP_DIV_PROD36K, C_NEVER,      ST_IDLE);
            6'd28: w = f_uw(OP_NOP,         C_DIV_BUSY,   ST_DIV_E);
            6'd29: w = f_uw(OP_SET_ANG,     C_NEVER,      ST_IDLE);
            6'd30: w = f_uw(OP_DIV_ANG100,  C_NEVER,      ST_IDLE);
            6'd31: w = f_uw(OP_NOP,         C_DIV_BUSY,   ST_DIV_F);
            6'd32: w = f_uw(OP_SET_DEG,     C_NEVER,      ST_IDLE);
            // hand the result to the output register
            6'd33: w = f_uw(OP_EMIT,        C_OUT_FULL,   ST_EMIT);
            6'd34: w = f_uw(OP_NOP,         C_ALWAYS,     ST_IDLE);
            default: w = f_uw(OP_NOP,       C_ALWAYS,     ST_IDLE);
        endcase
        return w;
    endfunction

    assign w_uw = f_rom(r_step);
    assign o_uw = w_uw;

    // Jump condition
    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:      w_take = 1'b0;
            C_ALWAYS:     w_take = 1'b1;
            C_NO_ITEM:    w_take = i_flags.no_item;
            C_NOT_FIRST:  w_take = !i_flags.first_hit;
            C_NOT_ROLL:   w_take = !i_flags.rolling;
            C_PRESS:      w_take = i_flags.press_hit;
            C_FLING:      w_take = i_flags.fling_hit;
            C_VEL_ZERO:   w_take = i_flags.vel_zero;
            C_DECEL_FULL: w_take = i_flags.decel_full;
            C_DIV_BUSY:   w_take = i_flags.div_busy;
            C_OUT_FULL:   w_take = i_flags.out_full;
            default:      w_take = 1'b0;
        endcase
        n_step = w_take ? w_uw.target : (r_step + STEP_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/kst_dpath.sv
// Scroll datapath: input latches, motion state, multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none
module kst_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kst_pkg::t_cfg     i_cfg,
    input  kst_pkg::t_uword   i_uw,
    input  kst_pkg::t_div_rsp i_div,
    output kst_pkg::t_div_req o_div,
    output kst_pkg::t_flags   o_flags,
    kst_in_if.sink            i_item,
    kst_out_if.source         o_result
);
    import kst_pkg::*;

    // Latched sample
    logic [7:0]  r_ftag, r_ptag, r_vtag;
    logic [31:0] r_dist, r_vel, r_total;
    // Motion state
    logic [31:0] r_base, r_drag, r_scroll, r_cvel, r_draw;
    logic        r_rolling;
    logic [16:0] r_ang;
    logic [9:0]  r_deg;
    // Product and output register
    logic [31:0] r_prod;
    logic        r_out_valid;
    logic [31:0] r_out_draw;
    logic [16:0] r_out_ang;
    logic [9:0]  r_out_deg;

    logic [6:0]         w_decel, w_keep;
    logic [7:0]         w_gain;
    logic [31:0]        w_dist, w_vel, w_total;
    logic [31:0]        w_mul_a, w_prod;
    logic [7:0]         w_mul_b;
    logic signed [31:0] w_q, w_v;
    logic               w_load, w_out_full, w_emit;

    // Effective percentages
    always_comb begin
        if (i_cfg.decel == 7'd0) begin
            w_decel = DEFAULT_PCT;
        end else if (i_cfg.decel > PCT_BASE) begin
            w_decel = PCT_BASE;
        end else begin
            w_decel = i_cfg.decel;
        end
        w_gain = (i_cfg.gain == 8'd0) ? {1'b0, DEFAULT_PCT} : i_cfg.gain;
        w_keep = PCT_BASE - w_decel;
    end

    // Sample intake with optional direction flip
    assign i_item.ready = (i_uw.op == OP_LOAD);
    assign w_load       = i_item.valid && (i_uw.op == OP_LOAD);

    always_comb begin
        w_dist  = {{16{i_item.drag_distance[15]}}, i_item.drag_distance};
        w_vel   = {{16{i_item.fling_velocity[15]}}, i_item.fling_velocity};
        w_total = i_item.fling_total;
        if (i_cfg.invert) begin
            w_dist  = 32'd0 - w_dist;
            w_vel   = 32'd0 - w_vel;
            w_total = 32'd0 - w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ftag  <= i_item.first_press_tag;
            r_ptag  <= i_item.press_tag;
            r_vtag  <= i_item.velocity_tag;
            r_dist  <= w_dist;
            r_vel   <= w_vel;
            r_total <= w_total;
        end
    end

    // Shared 32x8 multiplier, product wraps at 32 bits
    always_comb begin
        unique case (i_uw.op)
            OP_MUL_VD: begin
                w_mul_a = r_cvel;
                w_mul_b = {1'b0, w_keep};
            end
            OP_MUL_ANG: begin
                w_mul_a = 32'd0 - r_draw;
                w_mul_b = {3'd0, ANGLE_SCALE};
            end
            default: begin
                w_mul_a = r_scroll;
                w_mul_b = w_gain;
            end
        endcase
    end

    assign w_prod = w_mul_a * {24'd0, w_mul_b};

    always_ff @(posedge i_clk) begin
        if (i_uw.op == OP_MUL_SG || i_uw.op == OP_MUL_VD || i_uw.op == OP_MUL_ANG) begin
            r_prod <= w_prod;
        end
    end

    // Divider request
    assign o_div.start = (i_uw.op == OP_DIV_PROD100) || (i_uw.op == OP_DIV_PROD36K) ||
                         (i_uw.op == OP_DIV_ANG100);
    assign o_div.big   = (i_uw.op == OP_DIV_PROD36K);
    assign o_div.x     = (i_uw.op == OP_DIV_ANG100) ? {{15{r_ang[16]}}, r_ang} : r_prod;

    // Decayed velocity: magnitudes below the minimum speed stop
    assign w_q = i_div.quot;
    assign w_v = ((w_q > -MIN_SPEED) && (w_q < MIN_SPEED)) ? 32'sd0 : w_q;

    // Motion state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= 32'd0;
            r_drag    <= 32'd0;
            r_scroll  <= 32'd0;
            r_cvel    <= 32'd0;
            r_rolling <= 1'b0;
            r_draw    <= 32'd0;
            r_ang     <= 17'd0;
            r_deg     <= 10'd0;
        end else begin
            unique case (i_uw.op)
                OP_COMMIT: begin
                    r_base    <= r_base + w_q + r_drag;
                    r_cvel    <= 32'd0;
                    r_scroll  <= 32'd0;
                    r_rolling <= 1'b1;
                end
                OP_DECAY: begin
                    r_cvel   <= w_v;
                    r_scroll <= r_scroll + w_v;
                end
                OP_STOP: r_cvel <= 32'd0;
                OP_PRESS: begin
                    r_drag   <= r_dist;
                    r_cvel   <= 32'd0;
                    r_scroll <= 32'd0;
                end
                OP_FLING: begin
                    r_cvel   <= r_vel;
                    r_scroll <= r_total;
                end
                OP_SETTLE: begin
                    r_base   <= r_base + r_drag + w_q;
                    r_drag   <= 32'd0;
                    r_scroll <= 32'd0;
                end
                OP_DRAW:    r_draw <= r_base + w_q + r_drag;
                OP_SET_ANG: r_ang  <= i_div.rem[16:0];
                OP_SET_DEG: r_deg  <= i_div.quot[9:0];
                default: ;
            endcase
        end
    end

    // Output register
    assign w_out_full = r_out_valid && !o_result.ready;
    assign w_emit     = (i_uw.op == OP_EMIT) && !w_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_draw <= r_draw;
            r_out_ang  <= r_ang;
            r_out_deg  <= r_deg;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.render_pos       = r_out_draw;
    assign o_result.angle_hundredths = r_out_ang;
    assign o_result.angle_degrees    = r_out_deg;

    // Status for the sequencer
    assign o_flags.no_item    = !i_item.valid;
    assign o_flags.first_hit  = (r_ftag == i_cfg.tag);
    assign o_flags.rolling    = r_rolling;
    assign o_flags.press_hit  = (r_ptag == i_cfg.tag);
    assign o_flags.fling_hit  = (r_vel != 32'd0) && (r_vtag == i_cfg.tag);
    assign o_flags.vel_zero   = (r_cvel == 32'd0);
    assign o_flags.decel_full = (w_decel == PCT_BASE);
    assign o_flags.div_busy   = i_div.busy;
    assign o_flags.out_full   = w_out_full;

endmodule
`default_nettype wire

>>> rtl/core/kinetic_scroll_tracker_core.sv
// Top level of the kinetic scroll tracker: register port, sequencer, datapath, divider.
`timescale 1ns / 1ps
`default_nettype none
// One gesture sample per display frame goes in on i_item and one result (draw
// position, angle in hundredths and whole degrees) comes out on o_result for
// every sample. The block works on one sample at a time under a microcoded
// sequencer: a sample that finds the area not tracking skips the divider; a
// tracking sample waits on the shared divide-by-constant unit (reciprocal
// multiply, back-multiply, correction and sign fix), which it uses up to five
// times. A new sample is taken while the previous result still waits in the
// output register; a result that cannot be handed over holds the sequencer.
// Registers on the APB port: 0x0 tag, 0x4 deceleration percent, 0x8 gain
// percent, 0xC invert direction; write them only while the block is idle.
module kinetic_scroll_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    kst_in_if.sink      i_item,
    kst_out_if.source   o_result
);
    import kst_pkg::*;

    t_cfg     r_cfg;
    t_uword   w_uw;
    t_flags   w_flags;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    logic     w_wr;

    // Register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_TAG:    r_cfg.tag    <= pwdata[7:0];
                REG_DECEL:  r_cfg.decel  <= pwdata[6:0];
                REG_GAIN:   r_cfg.gain   <= pwdata[7:0];
                REG_INVERT: r_cfg.invert <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TAG:    prdata = {24'd0, r_cfg.tag};
            REG_DECEL:  prdata = {25'd0, r_cfg.decel};
            REG_GAIN:   prdata = {24'd0, r_cfg.gain};
            REG_INVERT: prdata = {31'd0, r_cfg.invert};
            default:    prdata = 32'd0;
        endcase
    end

    kst_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uw    (w_uw)
    );

    kst_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_uw     (w_uw),
        .i_div    (w_div_rsp),
        .o_div    (w_div_req),
        .o_flags  (w_flags),
        .i_item   (i_item),
        .o_result (o_result)
    );

    kst_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // The divider is only started once the previous division has finished
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    // A taken sample moves the sequencer off the intake step
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("intake still open after a sample was taken");

    // Angles delivered stay within one turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> ((o_result.angle_hundredths > -17'sd36000) &&
                            (o_result.angle_hundredths < 17'sd36000) &&
                            (o_result.angle_degrees > -10'sd360) &&
                            (o_result.angle_degrees < 10'sd360)))
        else $error("angle out of range");

endmodule
`default_nettype wire
